// ===== rtl/uffx_pkg.sv =====
package uffx_pkg;

    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int THRESH_W = 6;
    localparam int CFG_IDX_W = 3;

    // request kinds
    localparam logic [1:0] FUNC_LINE_RX  = 2'd0;
    localparam logic [1:0] FUNC_HOST_WR  = 2'd1;
    localparam logic [1:0] FUNC_HOST_RD  = 2'd2;
    localparam logic [1:0] FUNC_LINE_TX  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_HELD    = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESUME_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESUME_CHAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_CHAR = 3'd4;

    typedef struct packed {
        logic                flow_enable;
        logic [THRESH_W-1:0] stop_threshold;
        logic [THRESH_W-1:0] resume_threshold;
        logic [DATA_W-1:0]   resume_char;
        logic [DATA_W-1:0]   stop_char;
    } cfg_t;

    typedef struct packed {
        logic                we;
        logic [RX_PTR_W-1:0] waddr;
        logic [DATA_W-1:0]   wdata;
        logic                re;
        logic [RX_PTR_W-1:0] raddr;
    } rx_ram_req_t;

    typedef struct packed {
        logic                we;
        logic [TX_PTR_W-1:0] waddr;
        logic [DATA_W-1:0]   wdata;
        logic                re;
        logic [TX_PTR_W-1:0] raddr;
    } tx_ram_req_t;

    // report a count modulo 64
    function automatic logic [COUNT_W-1:0] count_field(input logic [31:0] v);
        return v[COUNT_W-1:0];
    endfunction

endpackage

// ===== rtl/uffx_ram.sv =====
module uffx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/uffx_cfg.sv =====
module uffx_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [uffx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [uffx_pkg::DATA_W-1:0]    cfg_data,
    output uffx_pkg::cfg_t                 cfg
);
    import uffx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_FLOW_ENABLE:   cfg_next.flow_enable = cfg_data[0];
                CFG_STOP_THRESH:   cfg_next.stop_threshold = cfg_data[THRESH_W-1:0];
                CFG_RESUME_THRESH: cfg_next.resume_threshold = cfg_data[THRESH_W-1:0];
                CFG_RESUME_CHAR:   cfg_next.resume_char = cfg_data;
                CFG_STOP_CHAR:     cfg_next.stop_char = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flow_enable      <= 1'b1;
            cfg_reg.stop_threshold   <= THRESH_W'(48);
            cfg_reg.resume_threshold <= THRESH_W'(16);
            cfg_reg.resume_char      <= DATA_W'(17);
            cfg_reg.stop_char        <= DATA_W'(19);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/uffx_ctrl.sv =====
module uffx_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  uffx_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic [uffx_pkg::DATA_W-1:0]  data_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   status,
    output logic [uffx_pkg::DATA_W-1:0]  data_out,
    output logic                         data_valid,
    output logic                         control_lost,
    output logic [uffx_pkg::COUNT_W-1:0] receive_count,
    output logic [uffx_pkg::COUNT_W-1:0] transmit_count,
    output uffx_pkg::rx_ram_req_t        rx_req,
    input  logic [uffx_pkg::DATA_W-1:0]  rx_rdata,
    output uffx_pkg::tx_ram_req_t        tx_req,
    input  logic [uffx_pkg::DATA_W-1:0]  tx_rdata
);
    import uffx_pkg::*;

    localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);
    localparam logic [RX_PTR_W:0]   RX_DEPTH_E = (RX_PTR_W + 1)'(RX_DEPTH);
    localparam logic [TX_PTR_W:0]   TX_DEPTH_E = (TX_PTR_W + 1)'(TX_DEPTH);

    logic [RX_PTR_W-1:0] rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    logic [TX_PTR_W-1:0] tx_wr_reg, tx_wr_next, tx_rd_reg, tx_rd_next;
    logic                send_allowed_reg, send_allowed_next;
    logic                peer_running_reg, peer_running_next;
    logic                pend_reg, pend_next;
    logic                push2_reg, push2_next;
    logic [2:0]          pend_status_reg, pend_status_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_lost_reg, pend_lost_next;
    logic                pend_src_tx_reg, pend_src_tx_next;
    logic                out_valid_reg, out_valid_next;
    logic [2:0]          out_status_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic                out_dvalid_reg;
    logic                out_lost_reg;
    logic [COUNT_W-1:0]  out_rx_cnt_reg;
    logic [COUNT_W-1:0]  out_tx_cnt_reg;

    logic [RX_PTR_W:0]   rx_diff, rx_wrap;
    logic [TX_PTR_W:0]   tx_diff, tx_wrap;
    logic [RX_PTR_W-1:0] rx_cnt;
    logic [TX_PTR_W-1:0] tx_cnt;
    logic [TX_PTR_W-1:0] tx_rd_dec;
    logic                tx_full;
    logic                accept;
    logic                move;
    logic                is_xon, is_xoff;
    logic                stop_hit, resume_hit, peer_after_stop;

    always_comb
    begin
        rx_diff = {1'b0, rx_wr_reg} - {1'b0, rx_rd_reg};
        rx_wrap = rx_diff + RX_DEPTH_E;
        rx_cnt  = (rx_wr_reg >= rx_rd_reg) ? rx_diff[RX_PTR_W-1:0] : rx_wrap[RX_PTR_W-1:0];
        tx_diff = {1'b0, tx_wr_reg} - {1'b0, tx_rd_reg};
        tx_wrap = tx_diff + TX_DEPTH_E;
        tx_cnt  = (tx_wr_reg >= tx_rd_reg) ? tx_diff[TX_PTR_W-1:0] : tx_wrap[TX_PTR_W-1:0];
    end

    assign tx_full   = (tx_cnt == TX_LAST);
    assign tx_rd_dec = (tx_rd_reg == '0) ? TX_LAST : tx_rd_reg - 1'b1;
    assign accept    = in_valid && !pend_reg;
    assign move      = pend_reg && !push2_reg && (!out_valid_reg || !out_stall);

    assign is_xon  = cfg.flow_enable && (data_in == cfg.resume_char);
    assign is_xoff = cfg.flow_enable && !is_xon && (data_in == cfg.stop_char);

    // threshold checks use the count before storing
    assign stop_hit = cfg.flow_enable && peer_running_reg
                      && (32'(rx_cnt) > 32'(cfg.stop_threshold));
    assign peer_after_stop = stop_hit ? 1'b0 : peer_running_reg;
    assign resume_hit = cfg.flow_enable && !peer_after_stop
                        && (32'(rx_cnt) < 32'(cfg.resume_threshold));

    always_comb
    begin
        rx_wr_next        = rx_wr_reg;
        rx_rd_next        = rx_rd_reg;
        tx_wr_next        = tx_wr_reg;
        tx_rd_next        = tx_rd_reg;
        send_allowed_next = send_allowed_reg;
        peer_running_next = peer_running_reg;
        pend_next         = pend_reg;
        push2_next        = push2_reg;
        pend_status_next  = pend_status_reg;
        pend_valid_next   = pend_valid_reg;
        pend_lost_next    = pend_lost_reg;
        pend_src_tx_next  = pend_src_tx_reg;
        rx_req            = '0;
        tx_req            = '0;

        // second control byte of a request that crossed both thresholds
        if (push2_reg)
        begin
            push2_next = 1'b0;
            if (tx_full)
            begin
                pend_lost_next = 1'b1;
            end
            else
            begin
                tx_req.we    = 1'b1;
                tx_req.waddr = tx_rd_dec;
                tx_req.wdata = cfg.resume_char;
                tx_rd_next   = tx_rd_dec;
            end
        end

        if (move)
        begin
            pend_next = 1'b0;
        end

        if (accept)
        begin
            pend_next        = 1'b1;
            pend_status_next = ST_OK;
            pend_valid_next  = 1'b0;
            pend_lost_next   = 1'b0;
            pend_src_tx_next = 1'b0;
            unique case (func)
                FUNC_LINE_RX:
                begin
                    if (is_xon)
                    begin
                        send_allowed_next = 1'b1;
                    end
                    else if (is_xoff)
                    begin
                        send_allowed_next = 1'b0;
                    end
                    else
                    begin
                        if (rx_cnt != RX_LAST)
                        begin
                            rx_req.we    = 1'b1;
                            rx_req.waddr = rx_wr_reg;
                            rx_req.wdata = data_in;
                            rx_wr_next   = (rx_wr_reg == RX_LAST) ? '0 : rx_wr_reg + 1'b1;
                        end
                        else
                        begin
                            pend_status_next = ST_DROPPED;
                        end
                        if (stop_hit || resume_hit)
                        begin
                            peer_running_next = resume_hit;
                            if (tx_full)
                            begin
                                pend_lost_next = 1'b1;
                            end
                            else
                            begin
                                tx_req.we    = 1'b1;
                                tx_req.waddr = tx_rd_dec;
                                tx_req.wdata = stop_hit ? cfg.stop_char : cfg.resume_char;
                                tx_rd_next   = tx_rd_dec;
                            end
                            push2_next = stop_hit && resume_hit;
                        end
                    end
                end
                FUNC_HOST_WR:
                begin
                    if (tx_full)
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        tx_req.we    = 1'b1;
                        tx_req.waddr = tx_wr_reg;
                        tx_req.wdata = data_in;
                        tx_wr_next   = (tx_wr_reg == TX_LAST) ? '0 : tx_wr_reg + 1'b1;
                    end
                end
                FUNC_HOST_RD:
                begin
                    if (rx_cnt == '0)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rx_req.re       = 1'b1;
                        rx_req.raddr    = rx_rd_reg;
                        pend_valid_next = 1'b1;
                        rx_rd_next      = (rx_rd_reg == RX_LAST) ? '0 : rx_rd_reg + 1'b1;
                    end
                end
                FUNC_LINE_TX:
                begin
                    if (tx_cnt == '0)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else if (cfg.flow_enable && !send_allowed_reg)
                    begin
                        pend_status_next = ST_HELD;
                    end
                    else
                    begin
                        tx_req.re        = 1'b1;
                        tx_req.raddr     = tx_rd_reg;
                        pend_valid_next  = 1'b1;
                        pend_src_tx_next = 1'b1;
                        tx_rd_next       = (tx_rd_reg == TX_LAST) ? '0 : tx_rd_reg + 1'b1;
                    end
                end
                default:
                begin
                    pend_status_next = ST_OK;
                end
            endcase
        end

        out_valid_next = move || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_reg        <= '0;
            rx_rd_reg        <= '0;
            tx_wr_reg        <= '0;
            tx_rd_reg        <= '0;
            send_allowed_reg <= 1'b1;
            peer_running_reg <= 1'b1;
            pend_reg         <= 1'b0;
            push2_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rx_wr_reg        <= rx_wr_next;
            rx_rd_reg        <= rx_rd_next;
            tx_wr_reg        <= tx_wr_next;
            tx_rd_reg        <= tx_rd_next;
            send_allowed_reg <= send_allowed_next;
            peer_running_reg <= peer_running_next;
            pend_reg         <= pend_next;
            push2_reg        <= push2_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_valid_reg  <= pend_valid_next;
        pend_lost_reg   <= pend_lost_next;
        pend_src_tx_reg <= pend_src_tx_next;
        // pointers are final here: no request is taken while one is pending
        if (move)
        begin
            out_status_reg <= pend_status_reg;
            out_dvalid_reg <= pend_valid_reg;
            out_lost_reg   <= pend_lost_reg;
            out_data_reg   <= !pend_valid_reg ? '0 : (pend_src_tx_reg ? tx_rdata : rx_rdata);
            out_rx_cnt_reg <= count_field(32'(rx_cnt));
            out_tx_cnt_reg <= count_field(32'(tx_cnt));
        end
    end

    assign in_stall       = pend_reg;
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign data_out       = out_data_reg;
    assign data_valid     = out_dvalid_reg;
    assign control_lost   = out_lost_reg;
    assign receive_count  = out_rx_cnt_reg;
    assign transmit_count = out_tx_cnt_reg;

endmodule

// ===== rtl/uart_fifo_xon_xoff_flow.sv =====
// Timing: a request is held in the pending register while its ring read completes, then moves
//   to the output registers; a line byte that sends both XOFF and XON waits while the second
//   control byte takes its own write, and a stalled output holds it. in_stall stays high while
//   a request is pending, so a new request is taken only after the last one has moved on.
// Reset: ring pointers cleared, send and peer flags go, registers at their defaults;
//   ring contents are not cleared, so no clearing pass follows reset.
module uart_fifo_xon_xoff_flow (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [uffx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [uffx_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     func,
    input  logic [uffx_pkg::DATA_W-1:0]    data_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [uffx_pkg::DATA_W-1:0]    data_out,
    output logic                           data_valid,
    output logic                           control_lost,
    output logic [uffx_pkg::COUNT_W-1:0]   receive_count,
    output logic [uffx_pkg::COUNT_W-1:0]   transmit_count
);
    import uffx_pkg::*;

    cfg_t              cfg;
    rx_ram_req_t       rx_req;
    tx_ram_req_t       tx_req;
    logic [DATA_W-1:0] rx_rdata;
    logic [DATA_W-1:0] tx_rdata;

    uffx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uffx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_req.we),
        .waddr (rx_req.waddr),
        .wdata (rx_req.wdata),
        .re    (rx_req.re),
        .raddr (rx_req.raddr),
        .rdata (rx_rdata)
    );

    uffx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_req.we),
        .waddr (tx_req.waddr),
        .wdata (tx_req.wdata),
        .re    (tx_req.re),
        .raddr (tx_req.raddr),
        .rdata (tx_rdata)
    );

    uffx_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .data_in        (data_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .data_out       (data_out),
        .data_valid     (data_valid),
        .control_lost   (control_lost),
        .receive_count  (receive_count),
        .transmit_count (transmit_count),
        .rx_req         (rx_req),
        .rx_rdata       (rx_rdata),
        .tx_req         (tx_req),
        .tx_rdata       (tx_rdata)
    );

endmodule

// ===== tb/uart_fifo_xon_xoff_flow_tb.sv =====
module uart_fifo_xon_xoff_flow_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uffx_pkg::*;

    typedef struct packed {
        logic [2:0]         status;
        logic [DATA_W-1:0]  data;
        logic               valid;
        logic               lost;
        logic [COUNT_W-1:0] rx_level;
        logic [COUNT_W-1:0] tx_level;
    } flow_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FLOW_ENABLE;
    logic [DATA_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           func = FUNC_LINE_RX;
    logic [DATA_W-1:0]    data_in = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           status;
    logic [DATA_W-1:0]    data_out;
    logic                 data_valid;
    logic                 control_lost;
    logic [COUNT_W-1:0]   receive_count;
    logic [COUNT_W-1:0]   transmit_count;

    // shadow copy of the block: settings, rings, pointers and flags
    cfg_t                shadow_cfg;
    logic [DATA_W-1:0]   rx_ring [RX_DEPTH];
    logic [DATA_W-1:0]   tx_ring [TX_DEPTH];
    logic [RX_PTR_W-1:0] rx_head;
    logic [RX_PTR_W-1:0] rx_tail;
    logic [TX_PTR_W-1:0] tx_head;
    logic [TX_PTR_W-1:0] tx_tail;
    logic                line_go;
    logic                peer_go;

    flow_result_t pending_results [$];

    int gap_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int settings_used = 0;
    int drops_seen = 0;
    int rejects_seen = 0;
    int holds_seen = 0;
    int lost_seen = 0;

    uart_fifo_xon_xoff_flow u_dut (.*);

    always #2 clk = ~clk;

    function automatic logic [RX_PTR_W-1:0] rx_fill();
        return rx_head - rx_tail;
    endfunction

    function automatic logic [TX_PTR_W-1:0] tx_fill();
        return tx_head - tx_tail;
    endfunction

    // control bytes go in ahead of queued data; drop them when the ring is full
    function automatic logic push_control(input logic [DATA_W-1:0] b);
        if (tx_fill() == TX_PTR_W'(TX_DEPTH - 1))
            return 1'b0;
        tx_tail = tx_tail - 1'b1;
        tx_ring[tx_tail] = b;
        return 1'b1;
    endfunction

    function automatic flow_result_t predict_flow_step(input logic [1:0] f,
                                                       input logic [DATA_W-1:0] d);
        flow_result_t        r;
        logic [RX_PTR_W-1:0] level;
        r = '0;
        case (f)
            FUNC_LINE_RX: begin
                if (shadow_cfg.flow_enable && d == shadow_cfg.resume_char)
                    line_go = 1'b1;
                else if (shadow_cfg.flow_enable && d == shadow_cfg.stop_char)
                    line_go = 1'b0;
                else
                begin
                    level = rx_fill();
                    if (level != RX_PTR_W'(RX_DEPTH - 1))
                    begin
                        rx_ring[rx_head] = d;
                        rx_head = rx_head + 1'b1;
                    end
                    else
                        r.status = ST_DROPPED;
                    if (shadow_cfg.flow_enable)
                    begin
                        if (level > shadow_cfg.stop_threshold && peer_go)
                        begin
                            peer_go = 1'b0;
                            if (!push_control(shadow_cfg.stop_char))
                                r.lost = 1'b1;
                        end
                        if (level < shadow_cfg.resume_threshold && !peer_go)
                        begin
                            peer_go = 1'b1;
                            if (!push_control(shadow_cfg.resume_char))
                                r.lost = 1'b1;
                        end
                    end
                end
            end
            FUNC_HOST_WR: begin
                if (tx_fill() == TX_PTR_W'(TX_DEPTH - 1))
                    r.status = ST_FULL;
                else
                begin
                    tx_ring[tx_head] = d;
                    tx_head = tx_head + 1'b1;
                end
            end
            FUNC_HOST_RD: begin
                if (rx_fill() == '0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.data = rx_ring[rx_tail];
                    r.valid = 1'b1;
                    rx_tail = rx_tail + 1'b1;
                end
            end
            default: begin
                if (tx_fill() == '0)
                    r.status = ST_EMPTY;
                else if (shadow_cfg.flow_enable && !line_go)
                    r.status = ST_HELD;
                else
                begin
                    r.data = tx_ring[tx_tail];
                    r.valid = 1'b1;
                    tx_tail = tx_tail + 1'b1;
                end
            end
        endcase
        r.rx_level = COUNT_W'(rx_fill());
        r.tx_level = COUNT_W'(tx_fill());
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] plain_byte();
        logic [DATA_W-1:0] b;
        do
            b = DATA_W'($urandom_range(255));
        while (b == shadow_cfg.resume_char || b == shadow_cfg.stop_char);
        return b;
    endfunction

    // bias toward control bytes and the extremes
    function automatic logic [DATA_W-1:0] pick_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return shadow_cfg.resume_char;
        if (roll < 24)
            return shadow_cfg.stop_char;
        if (roll < 30)
            return 8'h00;
        if (roll < 36)
            return 8'hFF;
        return DATA_W'($urandom_range(255));
    endfunction

    // profile 0 fills the rings, 1 empties them, 2 mixes evenly
    function automatic logic [1:0] pick_func(input int profile);
        int roll;
        roll = $urandom_range(99);
        case (profile)
            0: begin
                if (roll < 55) return FUNC_LINE_RX;
                if (roll < 85) return FUNC_HOST_WR;
                if (roll < 93) return FUNC_HOST_RD;
                return FUNC_LINE_TX;
            end
            1: begin
                if (roll < 8)  return FUNC_LINE_RX;
                if (roll < 16) return FUNC_HOST_WR;
                if (roll < 58) return FUNC_HOST_RD;
                return FUNC_LINE_TX;
            end
            default: begin
                if (roll < 25) return FUNC_LINE_RX;
                if (roll < 50) return FUNC_HOST_WR;
                if (roll < 75) return FUNC_HOST_RD;
                return FUNC_LINE_TX;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // check each result and draw the next stall
    always @(posedge clk)
    begin
        flow_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d data %0d",
                         $time, status, data_out);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.status == ST_DROPPED) drops_seen++;
                if (want.status == ST_FULL)    rejects_seen++;
                if (want.status == ST_HELD)    holds_seen++;
                if (want.lost)                 lost_seen++;
                if (status !== want.status)
                    report_mismatch("status", want.status, status);
                if (data_out !== want.data)
                    report_mismatch("data_out", want.data, data_out);
                if (data_valid !== want.valid)
                    report_mismatch("data_valid", want.valid, data_valid);
                if (control_lost !== want.lost)
                    report_mismatch("control_lost", want.lost, control_lost);
                if (receive_count !== want.rx_level)
                    report_mismatch("receive_count", want.rx_level, receive_count);
                if (transmit_count !== want.tx_level)
                    report_mismatch("transmit_count", want.tx_level, transmit_count);
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // valid stays high after acceptance; the next call or a drain lowers it
    task automatic send_request(input logic [1:0] f, input logic [DATA_W-1:0] d);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        data_in <= d;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_flow_step(f, d));
        requests_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // allow for the second control byte of a double control push
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input logic fe, input logic [THRESH_W-1:0] stop_th,
                                input logic [THRESH_W-1:0] resume_th,
                                input logic [DATA_W-1:0] xon, input logic [DATA_W-1:0] xoff);
        wait_idle();
        cfg_wen <= 1'b1;
        cfg_index <= CFG_FLOW_ENABLE;
        cfg_data <= DATA_W'(fe);
        @(posedge clk);
        cfg_index <= CFG_STOP_THRESH;
        cfg_data <= DATA_W'(stop_th);
        @(posedge clk);
        cfg_index <= CFG_RESUME_THRESH;
        cfg_data <= DATA_W'(resume_th);
        @(posedge clk);
        cfg_index <= CFG_RESUME_CHAR;
        cfg_data <= xon;
        @(posedge clk);
        cfg_index <= CFG_STOP_CHAR;
        cfg_data <= xoff;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        shadow_cfg.flow_enable = fe;
        shadow_cfg.stop_threshold = stop_th;
        shadow_cfg.resume_threshold = resume_th;
        shadow_cfg.resume_char = xon;
        shadow_cfg.stop_char = xoff;
        settings_used++;
    endtask

    task automatic test_directed_basics();
        send_request(FUNC_HOST_RD, 8'h00);
        send_request(FUNC_LINE_TX, 8'hFF);
        send_request(FUNC_HOST_WR, 8'h00);
        send_request(FUNC_HOST_WR, 8'hFF);
        send_request(FUNC_LINE_RX, 8'h00);
        send_request(FUNC_LINE_RX, 8'hFF);
        send_request(FUNC_LINE_RX, 8'hA5);
        send_request(FUNC_LINE_RX, 8'h5A);
        repeat (4) send_request(FUNC_HOST_RD, 8'h00);
        // close the transmit side from the line, try a slot, then reopen
        send_request(FUNC_LINE_RX, shadow_cfg.stop_char);
        send_request(FUNC_LINE_TX, 8'h00);
        send_request(FUNC_LINE_RX, shadow_cfg.resume_char);
        repeat (3) send_request(FUNC_LINE_TX, 8'h00);
        send_request(FUNC_HOST_RD, 8'h00);
    endtask

    // fill the receive ring past the stop level and into drops, then empty it
    task automatic test_receive_overflow();
        repeat (70) send_request(FUNC_LINE_RX, plain_byte());
        repeat (64) send_request(FUNC_HOST_RD, 8'h00);
        send_request(FUNC_LINE_RX, plain_byte());
        repeat (4) send_request(FUNC_LINE_TX, 8'h00);
    endtask

    // control bytes generated while the transmit ring is full
    task automatic test_control_lost();
        apply_config(1'b1, 6'd2, 6'd1, 8'd17, 8'd19);
        repeat (64) send_request(FUNC_HOST_WR, plain_byte());
        repeat (5) send_request(FUNC_LINE_RX, plain_byte());
        repeat (6) send_request(FUNC_HOST_RD, 8'h00);
        send_request(FUNC_LINE_RX, plain_byte());
        repeat (64) send_request(FUNC_LINE_TX, 8'h00);
        send_request(FUNC_HOST_RD, 8'h00);
    endtask

    task automatic test_threshold_corners();
        // stop below resume: one byte sends XOFF then XON
        apply_config(1'b1, 6'd0, 6'd63, 8'h00, 8'hFF);
        send_request(FUNC_HOST_RD, 8'h00);
        repeat (3) send_request(FUNC_LINE_RX, 8'h7E);
        send_request(FUNC_LINE_RX, 8'hFF);
        send_request(FUNC_LINE_TX, 8'h00);
        // flow control off: control values are plain data, transmit never held
        apply_config(1'b0, 6'd0, 6'd63, 8'h00, 8'hFF);
        send_request(FUNC_LINE_RX, 8'hFF);
        send_request(FUNC_LINE_RX, 8'h00);
        repeat (4) send_request(FUNC_LINE_TX, 8'h00);
        // one value for both control bytes reads as XON
        apply_config(1'b1, 6'd63, 6'd0, 8'h55, 8'h55);
        send_request(FUNC_LINE_RX, 8'h55);
        send_request(FUNC_LINE_TX, 8'h00);
        repeat (6) send_request(FUNC_HOST_RD, 8'h00);
    endtask

    task automatic test_random_traffic(input int n);
        int profile;
        profile = 2;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                profile = $urandom_range(2);
            // hold off now and then until every result is back
            if ($urandom_range(149) == 0)
                wait_idle();
            send_request(pick_func(profile), pick_byte());
        end
    endtask

    task automatic test_traffic_phase(input int sender_gap, input int receiver_stall,
                                      input int n);
        gap_pct = sender_gap;
        stall_pct = receiver_stall;
        test_random_traffic(n / 2);
        apply_config($urandom_range(3) != 0, THRESH_W'($urandom_range(63)),
                     THRESH_W'($urandom_range(63)), DATA_W'($urandom_range(255)),
                     DATA_W'($urandom_range(255)));
        test_random_traffic(n - n / 2);
    endtask

    initial
    begin
        int drain_cycles;
        shadow_cfg.flow_enable = 1'b1;
        shadow_cfg.stop_threshold = 6'd48;
        shadow_cfg.resume_threshold = 6'd16;
        shadow_cfg.resume_char = 8'd17;
        shadow_cfg.stop_char = 8'd19;
        rx_head = '0;
        rx_tail = '0;
        tx_head = '0;
        tx_tail = '0;
        line_go = 1'b1;
        peer_go = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_receive_overflow();
        test_control_lost();
        test_threshold_corners();

        apply_config(1'b1, 6'd48, 6'd16, 8'd17, 8'd19);
        test_traffic_phase(0, 0, 130);
        apply_config(1'b1, 6'd63, 6'd0, 8'h00, 8'hFF);
        test_traffic_phase(86, 0, 130);
        apply_config(1'b0, 6'd30, 6'd10, 8'h11, 8'h13);
        test_traffic_phase(0, 86, 130);
        apply_config(1'b1, 6'd40, 6'd20, DATA_W'($urandom_range(255)),
                     DATA_W'($urandom_range(255)));
        test_traffic_phase(26, 26, 130);

        in_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < 100000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
                     $time, pending_results.size(), pending_results.size());
        end
        $display("Sent %0d requests under %0d register settings and four idle/stall mixes;",
                 requests_sent, settings_used);
        $display("checked %0d results: %0d drops, %0d rejected writes, %0d held, %0d lost.",
                 results_checked, drops_seen, rejects_seen, holds_seen, lost_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
